### design/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
package hcbp_pkg;

  // operation codes carried on the input channel
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // fixed field widths
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // one job handed from the front to the back
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } job_t;

endpackage

### design/hcbp_front.sv
// front end: accepts transactions, keeps the code table, classifies jobs
module hcbp_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_symbol,
  input  logic [31:0]        in_code_bits,
  input  logic [5:0]         in_code_length,
  output logic               q_push,
  output hcbp_pkg::job_t     q_job,
  input  logic               q_full
);
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CW      = LEN_CAP;
  localparam int AW      = $clog2(SYMBOL_COUNT);

  // code table storage
  logic [CW-1:0]    tbl_code_r  [SYMBOL_COUNT];
  logic [LEN_W-1:0] tbl_len_r   [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_valid_r;

  // lookup stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_flush_r;
  logic [CW-1:0]    rd_code_r;
  logic [LEN_W-1:0] rd_len_r;
  logic             rd_ok_r;

  logic             accept;
  logic             is_load, is_enc, is_flush;
  logic             in_range;
  logic [AW-1:0]    addr;
  logic [LEN_W-1:0] ld_len;
  logic [32:0]      ld_mask;
  logic [CODE_W-1:0] ld_code;
  logic [LEN_W-1:0] s1_len;
  logic             s1_need;
  logic             s1_stall;

  // decode the operation
  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    case (in_operation)
      OP_LOAD:   is_load  = 1'b1;
      OP_ENCODE: is_enc   = 1'b1;
      OP_FLUSH:  is_flush = 1'b1;
      default:   is_load  = 1'b0;
    endcase
  end

  assign in_range = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign addr     = in_symbol[AW-1:0];

  // saturate the length and clear code bits above it
  assign ld_len  = (in_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_code_length;
  assign ld_mask = (33'd1 << ld_len) - 33'd1;
  assign ld_code = in_code_bits & ld_mask[CODE_W-1:0];

  // lookup stage hands a job on unless it is an encode that carries no bits
  assign s1_len   = rd_ok_r ? rd_len_r : '0;
  assign s1_need  = s1_flush_r || (s1_len != '0);
  assign s1_stall = s1_valid_r && s1_need && q_full;
  assign q_push   = s1_valid_r && s1_need && !q_full;
  assign in_full  = s1_stall;
  assign accept   = in_push && !s1_stall;

  assign q_job.is_flush = s1_flush_r;
  assign q_job.len      = s1_flush_r ? '0 : s1_len;
  assign q_job.code     = CODE_W'(rd_code_r);

  // lookup stage occupancy
  always_comb begin
    if (s1_stall) begin
      s1_valid_nxt = 1'b1;
    end else begin
      s1_valid_nxt = accept && ((is_enc && in_range) || is_flush);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush_r <= is_flush;
    end
  end

  // table valid bits: a never loaded entry reads as length zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
    end else if (accept && is_load && in_range) begin
      tbl_valid_r[addr] <= 1'b1;
    end
  end

  // table write on load, registered read on encode
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      tbl_code_r[addr] <= CW'(ld_code);
      tbl_len_r[addr]  <= ld_len;
    end
    if (accept && is_enc && in_range) begin
      rd_code_r <= tbl_code_r[addr];
      rd_len_r  <= tbl_len_r[addr];
      rd_ok_r   <= tbl_valid_r[addr];
    end
  end

endmodule

### design/hcbp_fifo.sv
// short job queue between the front end and the bit packer
module hcbp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hcbp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output hcbp_pkg::job_t head,
  output logic           empty
);
  import hcbp_pkg::*;

  job_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/hcbp_back.sv
// back end: packs code bits into bytes and drives the output register
module hcbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hcbp_pkg::job_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import hcbp_pkg::*;

  // current job
  logic              cur_valid_r, cur_valid_nxt;
  logic              cur_flush_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  rem_r;

  // bit accumulator
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [2:0]        fill_r, fill_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [3:0]        room, take, sum;
  logic [BYTE_W-1:0] take_mask, merged;
  logic [LEN_W-1:0]  rem_left;
  logic              emit, emit_last, done, step, slot_free, load_cur;
  logic [BYTE_W-1:0] emit_byte;

  assign slot_free = !out_valid_r || out_pop;

  // bits to take this cycle: up to the room left in the byte
  always_comb begin
    room      = 4'd8 - {1'b0, fill_r};
    take      = (rem_r < LEN_W'(room)) ? rem_r[3:0] : room;
    sum       = {1'b0, fill_r} + take;
    take_mask = BYTE_W'((9'd1 << take) - 9'd1);
    merged    = acc_r | BYTE_W'((code_r[BYTE_W-1:0] & take_mask) << fill_r);
    rem_left  = rem_r - LEN_W'(take);
  end

  // what the current job does in this cycle
  always_comb begin
    if (cur_flush_r) begin
      emit      = (fill_r != 3'd0);
      emit_last = 1'b1;
      emit_byte = acc_r;
      done      = 1'b1;
      acc_nxt   = '0;
      fill_nxt  = 3'd0;
    end else begin
      emit      = sum[3];
      emit_last = (rem_left < LEN_W'(8));
      emit_byte = merged;
      done      = (rem_left == '0);
      acc_nxt   = sum[3] ? '0 : merged;
      fill_nxt  = sum[2:0];
    end
  end

  assign step     = cur_valid_r && (!emit || slot_free);
  assign load_cur = !q_empty && (!cur_valid_r || (step && done));
  assign q_pop    = load_cur;

  always_comb begin
    if (load_cur) begin
      cur_valid_nxt = 1'b1;
    end else if (step && done) begin
      cur_valid_nxt = 1'b0;
    end else begin
      cur_valid_nxt = cur_valid_r;
    end
  end

  always_comb begin
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      fill_r      <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        acc_r  <= acc_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  // current job payload
  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_flush_r <= head.is_flush;
      code_r      <= head.code;
      rem_r       <= head.len;
    end else if (step) begin
      code_r <= code_r >> take;
      rem_r  <= rem_left;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && cur_flush_r && emit |=> out_valid_r && out_last_r)
    else $error("flush byte not marked last");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && cur_flush_r |=> fill_r == 3'd0)
    else $error("flush left bits in the accumulator");

  a_not_last_continues: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit && !emit_last |=> cur_valid_r && !cur_flush_r)
    else $error("non-final byte but job ended");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> rem_r <= LEN_W'(CODE_W))
    else $error("remaining length out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r && $stable(out_byte_r))
    else $error("pending output byte overwritten");
`endif

endmodule

### design/huffman_code_bit_packer_unit.sv
// top level of the table-driven huffman code bit packer
// Takes one transaction per cycle while full is low. A load writes one code table entry; an
// encode looks up the symbol and appends its code bits to a byte accumulator, first code bit
// in byte bit 0; a flush zero-pads and emits a partial byte if bits are pending. The front
// end (a registered table lookup) feeds a four-entry job queue. The back end packer works
// through a code in pieces, one piece per cycle while the output register can take a byte,
// where a piece ends at a byte boundary or at the end of the code. The queue absorbs the
// bursts while the packer is busy. Results leave through an output register, one byte per
// cycle while the consumer pops. Between an accepted transaction and its byte at the output
// ports lie the lookup register, the queue write, the packer load and the output register.
// The table needs no clearing after reset.
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import hcbp_pkg::*;

  job_t q_in_job, q_head;
  logic q_push, q_full, q_pop, q_empty;

  // front end: table and lookup
  hcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (push),
    .in_full       (full),
    .in_operation  (in_operation),
    .in_symbol     (in_symbol),
    .in_code_bits  (in_code_bits),
    .in_code_length(in_code_length),
    .q_push        (q_push),
    .q_job         (q_in_job),
    .q_full        (q_full)
  );

  // job queue
  hcbp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_in_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // back end: bit packer and output register
  hcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_empty(empty),
    .out_pop  (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
